// ===== design/minmod_gradient_limiter_top_macros.svh =====
// Assertion helpers for the gradient limiter.
`ifndef MINMOD_GRADIENT_LIMITER_TOP_MACROS_SVH
`define MINMOD_GRADIENT_LIMITER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MGL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MGL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mgl_pkg.sv =====
package mgl_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int THR_WIDTH   = 16;
  localparam int SLOT_WIDTH  = 2;
  localparam int DIGIT_WIDTH = 4;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_SUM,
    ST_CLS,
    ST_DIV,
    ST_MIN,
    ST_FIN,
    ST_SCL
  } state_e;

endpackage

// ===== design/mgl_if.sv =====
interface mgl_in_if;
  logic                          valid;
  logic                          ready;
  mgl_pkg::value_t               cell_value;
  mgl_pkg::value_t               grad_x;
  mgl_pkg::value_t               grad_y;
  mgl_pkg::value_t               other_value;
  mgl_pkg::value_t               dir_x;
  mgl_pkg::value_t               dir_y;
  logic                          at_boundary;
  logic [mgl_pkg::SLOT_WIDTH-1:0] face_slot;
  logic                          last_face;

  modport source (
    output valid, cell_value, grad_x, grad_y, other_value, dir_x, dir_y,
           at_boundary, face_slot, last_face,
    input  ready
  );

  modport sink (
    input  valid, cell_value, grad_x, grad_y, other_value, dir_x, dir_y,
           at_boundary, face_slot, last_face,
    output ready
  );
endinterface

interface mgl_out_if;
  logic            valid;
  logic            ready;
  mgl_pkg::value_t limited_x;
  mgl_pkg::value_t limited_y;

  modport source (
    output valid, limited_x, limited_y,
    input  ready
  );

  modport sink (
    input  valid, limited_x, limited_y,
    output ready
  );
endinterface

// ===== design/mgl_smul.sv =====
module mgl_smul #(
  parameter int A_WIDTH = 32,
  parameter int B_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [A_WIDTH-1:0] a_i,
  input  logic signed [B_WIDTH-1:0] b_i,
  output logic                      busy_o,
  output logic signed [A_WIDTH+((B_WIDTH+mgl_pkg::DIGIT_WIDTH-1)/mgl_pkg::DIGIT_WIDTH)
                       *mgl_pkg::DIGIT_WIDTH-1:0] p_o
);

  localparam int DW        = mgl_pkg::DIGIT_WIDTH;
  localparam int STEPS     = (B_WIDTH + DW - 1) / DW;
  localparam int BX_WIDTH  = STEPS * DW;
  localparam int ACC_WIDTH = A_WIDTH + DW + 1;
  localparam int CNT_WIDTH = $clog2(STEPS + 1);

  logic signed [A_WIDTH-1:0]   a_q;
  logic        [BX_WIDTH-1:0]  b_q;
  logic signed [ACC_WIDTH-1:0] acc_q;
  logic        [BX_WIDTH-1:0]  lo_q;
  logic        [CNT_WIDTH-1:0] cnt_q;

  logic                        last_step;
  logic signed [DW:0]          digit;
  logic signed [ACC_WIDTH-1:0] pp;
  logic signed [ACC_WIDTH-1:0] sum;

  assign last_step = (cnt_q == CNT_WIDTH'(1));
  assign digit     = {last_step & b_q[DW-1], b_q[DW-1:0]};
  assign pp        = ACC_WIDTH'(a_q) * ACC_WIDTH'(digit);
  assign sum       = acc_q + pp;
  assign busy_o    = (cnt_q != '0);
  assign p_o       = {acc_q[A_WIDTH-1:0], lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_WIDTH'(STEPS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BX_WIDTH'(b_i);
      acc_q <= '0;
      lo_q  <= '0;
    end else if (busy_o) begin
      // retire one digit: low bits move into the product shift register
      b_q   <= b_q >> DW;
      acc_q <= sum >>> DW;
      lo_q  <= {sum[DW-1:0], lo_q[BX_WIDTH-1:DW]};
    end
  end

endmodule

// ===== design/mgl_div.sv =====
module mgl_div #(
  parameter int NUM_WIDTH = 32,
  parameter int DEN_WIDTH = 51,
  parameter int Q_WIDTH   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] num_i,
  input  logic [DEN_WIDTH-1:0] den_i,
  output logic                 busy_o,
  output logic [Q_WIDTH-1:0]   quot_o
);

  localparam int CNT_WIDTH = $clog2(Q_WIDTH + 1);

  logic [DEN_WIDTH-1:0] rem_q;
  logic [DEN_WIDTH-1:0] den_q;
  logic [Q_WIDTH-1:0]   quot_q;
  logic [CNT_WIDTH-1:0] cnt_q;

  logic [DEN_WIDTH:0]   rem2;
  logic [DEN_WIDTH+1:0] diff;
  logic                 ge;

  assign rem2   = {rem_q, 1'b0};
  assign diff   = {1'b0, rem2} - {2'b00, den_q};
  assign ge     = ~diff[DEN_WIDTH+1];
  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_WIDTH'(Q_WIDTH);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DEN_WIDTH'(num_i);
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_o) begin
      rem_q  <= ge ? diff[DEN_WIDTH-1:0] : rem2[DEN_WIDTH-1:0];
      quot_q <= {quot_q[Q_WIDTH-2:0], ge};
    end
  end

endmodule

// ===== design/minmod_gradient_limiter_top.sv =====
// Minmod gradient limiter, one cell face per input beat. Each face forms
// downwind = grad . dir (doubled at a boundary, exact floor of the Q format)
// and upwind = other - cell, reduces them to a ratio in [0,1] (one when
// |downwind| <= zero_threshold) and folds it into the x minimum (slots 1, 3)
// or the y minimum (slots 0, 2). A beat with last_face set yields one output
// beat: both gradient components times their minima, floored; the minima
// then return to one. Write zero_threshold only while the block is idle.
// A face occupies the block from acceptance to the next ready; its ratio
// either resolves directly or goes to the radix-2 divider, one quotient bit
// per cycle. The dot product runs through two digit-serial multipliers, 4
// multiplier bits per cycle; the last face of a cell reuses the same
// multipliers for the output scaling. Input is taken while an earlier
// output beat still waits; a last face then holds the block in its scaling
// step until that beat leaves.
module minmod_gradient_limiter_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mgl_pkg::THR_WIDTH-1:0] cfg_data_i,
  mgl_in_if.sink                        in_i,
  mgl_out_if.source                     out_o
);

`include "minmod_gradient_limiter_top_macros.svh"

  localparam int VW          = mgl_pkg::VALUE_WIDTH;
  localparam int DIG         = mgl_pkg::DIGIT_WIDTH;
  localparam int MUL_PW      = VW + ((VW + DIG - 1) / DIG) * DIG;
  localparam int SUM_WIDTH   = MUL_PW + 1;
  localparam int DOWN_WIDTH  = SUM_WIDTH - FRAC_BITS;
  localparam int DOWN2_WIDTH = DOWN_WIDTH + 1;
  localparam int MAG_WIDTH   = DOWN2_WIDTH;
  localparam int UP_WIDTH    = VW + 1;
  localparam int AU_WIDTH    = VW;
  localparam int RATIO_WIDTH = FRAC_BITS + 1;
  localparam logic [RATIO_WIDTH-1:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  mgl_pkg::state_e state_q, state_d;

  logic [mgl_pkg::THR_WIDTH-1:0]  thr_q;
  mgl_pkg::value_t                grad_x_q;
  mgl_pkg::value_t                grad_y_q;
  logic signed [UP_WIDTH-1:0]     up_q;
  logic                           boundary_q;
  logic [mgl_pkg::SLOT_WIDTH-1:0] slot_q;
  logic                           last_q;
  logic signed [DOWN2_WIDTH-1:0]  down2_q;
  logic [MAG_WIDTH-1:0]           ad_q;
  logic [AU_WIDTH-1:0]            au_q;
  logic [RATIO_WIDTH-1:0]         ratio_q;
  logic [RATIO_WIDTH-1:0]         min_x_q;
  logic [RATIO_WIDTH-1:0]         min_y_q;
  logic                           out_valid_q;
  mgl_pkg::value_t                lim_x_q;
  mgl_pkg::value_t                lim_y_q;

  logic                           in_fire;
  logic                           mul_start;
  logic                           mul_busy;
  logic                           busy_x;
  logic                           busy_y;
  mgl_pkg::value_t                mul_a_x;
  mgl_pkg::value_t                mul_a_y;
  mgl_pkg::value_t                mul_b_x;
  mgl_pkg::value_t                mul_b_y;
  logic signed [MUL_PW-1:0]       p_x;
  logic signed [MUL_PW-1:0]       p_y;
  logic signed [SUM_WIDTH-1:0]    sum_w;
  logic signed [DOWN_WIDTH-1:0]   down_w;
  logic signed [DOWN2_WIDTH-1:0]  down2_d;
  logic                           div_start;
  logic                           div_busy;
  logic [FRAC_BITS-1:0]           quot;
  logic                           ratio_one;
  logic                           ratio_zero;
  logic                           ld_ratio_cls;
  logic                           ld_ratio_div;
  logic                           upd_min;
  logic                           clr_min;
  logic                           out_load;
  logic                           out_free;

  assign in_fire  = in_i.valid & in_i.ready;
  assign mul_busy = busy_x | busy_y;
  assign out_free = ~out_valid_q | out_o.ready;

  assign mul_a_x = (state_q == mgl_pkg::ST_IDLE) ? in_i.grad_x : grad_x_q;
  assign mul_a_y = (state_q == mgl_pkg::ST_IDLE) ? in_i.grad_y : grad_y_q;
  assign mul_b_x = (state_q == mgl_pkg::ST_IDLE) ? in_i.dir_x
                                                 : {{(VW-RATIO_WIDTH){1'b0}}, min_x_q};
  assign mul_b_y = (state_q == mgl_pkg::ST_IDLE) ? in_i.dir_y
                                                 : {{(VW-RATIO_WIDTH){1'b0}}, min_y_q};

  mgl_smul #(
    .A_WIDTH (VW),
    .B_WIDTH (VW)
  ) u_mul_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a_x),
    .b_i     (mul_b_x),
    .busy_o  (busy_x),
    .p_o     (p_x)
  );

  mgl_smul #(
    .A_WIDTH (VW),
    .B_WIDTH (VW)
  ) u_mul_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a_y),
    .b_i     (mul_b_y),
    .busy_o  (busy_y),
    .p_o     (p_y)
  );

  mgl_div #(
    .NUM_WIDTH (AU_WIDTH),
    .DEN_WIDTH (MAG_WIDTH),
    .Q_WIDTH   (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (au_q),
    .den_i   (ad_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign sum_w   = SUM_WIDTH'(p_x) + SUM_WIDTH'(p_y);
  assign down_w  = sum_w[SUM_WIDTH-1:FRAC_BITS];
  assign down2_d = boundary_q ? {down_w, 1'b0} : {down_w[DOWN_WIDTH-1], down_w};

  assign ratio_one  = (ad_q <= MAG_WIDTH'(thr_q)) || (MAG_WIDTH'(au_q) >= ad_q);
  assign ratio_zero = (up_q == '0) || (up_q[UP_WIDTH-1] != down2_q[DOWN2_WIDTH-1]);

  always_comb begin
    state_d      = state_q;
    in_i.ready   = 1'b0;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    ld_ratio_cls = 1'b0;
    ld_ratio_div = 1'b0;
    upd_min      = 1'b0;
    clr_min      = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      mgl_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          mul_start = 1'b1;
          state_d   = mgl_pkg::ST_DOT;
        end
      end
      mgl_pkg::ST_DOT: begin
        if (!mul_busy) begin
          state_d = mgl_pkg::ST_SUM;
        end
      end
      mgl_pkg::ST_SUM: begin
        state_d = mgl_pkg::ST_CLS;
      end
      mgl_pkg::ST_CLS: begin
        if ((ad_q <= MAG_WIDTH'(thr_q)) || ratio_zero || ratio_one) begin
          ld_ratio_cls = 1'b1;
          state_d      = mgl_pkg::ST_MIN;
        end else begin
          div_start = 1'b1;
          state_d   = mgl_pkg::ST_DIV;
        end
      end
      mgl_pkg::ST_DIV: begin
        if (!div_busy) begin
          ld_ratio_div = 1'b1;
          state_d      = mgl_pkg::ST_MIN;
        end
      end
      mgl_pkg::ST_MIN: begin
        upd_min = 1'b1;
        state_d = last_q ? mgl_pkg::ST_FIN : mgl_pkg::ST_IDLE;
      end
      mgl_pkg::ST_FIN: begin
        mul_start = 1'b1;
        clr_min   = 1'b1;
        state_d   = mgl_pkg::ST_SCL;
      end
      mgl_pkg::ST_SCL: begin
        if (!mul_busy && out_free) begin
          out_load = 1'b1;
          state_d  = mgl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mgl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mgl_pkg::ST_IDLE;
      thr_q       <= '0;
      min_x_q     <= RATIO_ONE;
      min_y_q     <= RATIO_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (clr_min) begin
        min_x_q <= RATIO_ONE;
        min_y_q <= RATIO_ONE;
      end else if (upd_min) begin
        if (slot_q[0] && (ratio_q < min_x_q)) begin
          min_x_q <= ratio_q;
        end
        if (!slot_q[0] && (ratio_q < min_y_q)) begin
          min_y_q <= ratio_q;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      grad_x_q   <= in_i.grad_x;
      grad_y_q   <= in_i.grad_y;
      up_q       <= UP_WIDTH'(in_i.other_value) - UP_WIDTH'(in_i.cell_value);
      boundary_q <= in_i.at_boundary;
      slot_q     <= in_i.face_slot;
      last_q     <= in_i.last_face;
    end
    if ((state_q == mgl_pkg::ST_DOT) && !mul_busy) begin
      down2_q <= down2_d;
    end
    if (state_q == mgl_pkg::ST_SUM) begin
      ad_q <= down2_q[DOWN2_WIDTH-1] ? -down2_q : down2_q;
      au_q <= up_q[UP_WIDTH-1] ? AU_WIDTH'(-up_q) : AU_WIDTH'(up_q);
    end
    if (ld_ratio_cls) begin
      // threshold hit wins over sign test, sign test over saturation
      if (ad_q <= MAG_WIDTH'(thr_q)) begin
        ratio_q <= RATIO_ONE;
      end else if (ratio_zero) begin
        ratio_q <= '0;
      end else begin
        ratio_q <= RATIO_ONE;
      end
    end else if (ld_ratio_div) begin
      ratio_q <= {1'b0, quot};
    end
    if (out_load) begin
      lim_x_q <= p_x[FRAC_BITS+VW-1:FRAC_BITS];
      lim_y_q <= p_y[FRAC_BITS+VW-1:FRAC_BITS];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.limited_x = lim_x_q;
  assign out_o.limited_y = lim_y_q;

  `MGL_ASSERT_IMPLY(a_min_bound, clk_i, rst_ni, 1'b1,
                    (min_x_q <= RATIO_ONE) && (min_y_q <= RATIO_ONE),
                    "running minimum above one")
  `MGL_ASSERT_IMPLY(a_div_operands, clk_i, rst_ni, div_start,
                    (MAG_WIDTH'(au_q) < ad_q) && (ad_q > MAG_WIDTH'(thr_q)),
                    "divider started outside its range")
  `MGL_ASSERT_NEXT(a_out_load, clk_i, rst_ni, out_load,
                   out_valid_q && (state_q == mgl_pkg::ST_IDLE) && (min_x_q == RATIO_ONE),
                   "output beat not presented after scaling")

endmodule
